// ===== rtl/vipsac_pkg.sv =====
// shared types, codes and address helpers for the subnet admission check
`timescale 1ns / 1ps
`default_nettype none

package vipsac_pkg;

    // default number of entries in each subnet list
    localparam int LIST_DEPTH_DEFAULT = 8;

    // full prefix lengths per family
    localparam logic [7:0] V4_FULL = 8'd32;
    localparam logic [7:0] V6_FULL = 8'd128;

    // item kinds carried on s_tuser
    typedef enum logic [2:0] {
        KIND_CLEAR     = 3'd0,
        KIND_ADD_INCL  = 3'd1,
        KIND_ADD_EXCL  = 3'd2,
        KIND_ADD_SPEC  = 3'd3,
        KIND_CHECK     = 3'd4
    } kind_t;

    // check verdicts
    typedef enum logic [2:0] {
        VERD_OK        = 3'd0,
        VERD_HOST_ONLY = 3'd1,
        VERD_NOT_PRIV  = 3'd2,
        VERD_EXCLUDED  = 3'd3,
        VERD_NOT_SPEC  = 3'd4
    } verdict_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_VIRT_PRESENT  = 3'd0,
        CFG_HOST_ONLY     = 3'd1,
        CFG_ALLOW_OWN     = 3'd2,
        CFG_USE_PRIVATE   = 3'd3,
        CFG_ALLOW_ALL     = 3'd4
    } cfg_idx_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // normalised subnet
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
        logic        v6;
    } net_t;

    // one flag per list
    typedef struct packed {
        logic incl;
        logic excl;
        logic spec;
    } list_sel_t;

    // probe walking along the cell row
    typedef struct packed {
        logic      valid;
        net_t      net;
        list_sel_t hit;
    } probe_t;

    // clamp prefix and drop bits outside the family
    function automatic net_t make_net(logic [63:0] hi, logic [63:0] lo,
                                      logic [7:0] plen, logic v6);
        net_t n;
        n.v6 = v6;
        if (v6) begin
            n.plen = (plen > V6_FULL) ? V6_FULL : plen;
            n.hi   = hi;
            n.lo   = lo;
        end else begin
            n.plen = (plen > V4_FULL) ? V4_FULL : plen;
            n.hi   = 64'd0;
            n.lo   = {32'd0, lo[31:0]};
        end
        return n;
    endfunction

    // prefix mask across the 128-bit address word
    function automatic logic [127:0] prefix_mask(logic [7:0] plen, logic v6);
        logic [127:0] m;
        if (v6) begin
            m = {128{1'b1}} << (V6_FULL - plen);
        end else begin
            m = {96'd0, (32'hFFFF_FFFF << (V4_FULL - plen))};
        end
        return m;
    endfunction

    // true when subnet a lies inside list subnet b
    function automatic logic net_inside(net_t a, net_t b);
        logic [127:0] m;
        logic [127:0] diff;
        m    = prefix_mask(b.plen, b.v6);
        diff = {a.hi, a.lo} ^ {b.hi, b.lo};
        return (a.v6 == b.v6) && (a.plen >= b.plen) && ((diff & m) == 128'd0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vipsac_cell.sv =====
// one cell of the row: holds one entry of each list and tests the passing probe
`timescale 1ns / 1ps
`default_nettype none

module vipsac_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire vipsac_pkg::list_sel_t wr_en,
    input  wire vipsac_pkg::net_t      wr_data,
    input  wire vipsac_pkg::list_sel_t live,
    input  wire vipsac_pkg::probe_t    probe_in,
    output vipsac_pkg::probe_t         probe_out
);

    vipsac_pkg::net_t   incl_ent_reg;
    vipsac_pkg::net_t   excl_ent_reg;
    vipsac_pkg::net_t   spec_ent_reg;
    vipsac_pkg::probe_t probe_reg;
    vipsac_pkg::probe_t probe_next;

    // entry storage, written on append
    always_ff @(posedge aclk) begin
        if (wr_en.incl) begin
            incl_ent_reg <= wr_data;
        end
        if (wr_en.excl) begin
            excl_ent_reg <= wr_data;
        end
        if (wr_en.spec) begin
            spec_ent_reg <= wr_data;
        end
    end

    // fold this cell's containment tests into the probe
    always_comb begin
        probe_next          = probe_in;
        probe_next.hit.incl = probe_in.hit.incl |
                              (live.incl & vipsac_pkg::net_inside(probe_in.net, incl_ent_reg));
        probe_next.hit.excl = probe_in.hit.excl |
                              (live.excl & vipsac_pkg::net_inside(probe_in.net, excl_ent_reg));
        probe_next.hit.spec = probe_in.hit.spec |
                              (live.spec & vipsac_pkg::net_inside(probe_in.net, spec_ent_reg));
    end

    // hand the probe to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.net <= probe_next.net;
        probe_reg.hit <= probe_next.hit;
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

// ===== rtl/vipsac_chain.sv =====
// row of list cells with write decode and per-cell entry qualification
`timescale 1ns / 1ps
`default_nettype none

module vipsac_chain #(
    parameter int LIST_DEPTH = vipsac_pkg::LIST_DEPTH_DEFAULT,
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire vipsac_pkg::list_sel_t wr_req,
    input  wire vipsac_pkg::net_t      wr_data,
    input  wire logic [CNT_W-1:0]      incl_count,
    input  wire logic [CNT_W-1:0]      excl_count,
    input  wire logic [CNT_W-1:0]      spec_count,
    input  wire vipsac_pkg::probe_t    probe_in,
    output vipsac_pkg::probe_t         probe_out
);

    vipsac_pkg::probe_t link [0:LIST_DEPTH];

    assign link[0] = probe_in;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        vipsac_pkg::list_sel_t cell_wr;
        vipsac_pkg::list_sel_t cell_live;

        // append lands in the cell at the current fill level
        assign cell_wr.incl   = wr_req.incl & (incl_count == CNT_W'(i));
        assign cell_wr.excl   = wr_req.excl & (excl_count == CNT_W'(i));
        assign cell_wr.spec   = wr_req.spec & (spec_count == CNT_W'(i));

        // only entries below the fill level take part
        assign cell_live.incl = CNT_W'(i) < incl_count;
        assign cell_live.excl = CNT_W'(i) < excl_count;
        assign cell_live.spec = CNT_W'(i) < spec_count;

        vipsac_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (cell_wr),
            .wr_data   (wr_data),
            .live      (cell_live),
            .probe_in  (link[i]),
            .probe_out (link[i+1])
        );
    end

    assign probe_out = link[LIST_DEPTH];

endmodule

`default_nettype wire

// ===== rtl/virtual_ip_subnet_admission_check.sv =====
// top level: subnet list admission check with a row of list cells
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata subnet and peer, s_tuser kind
//  m_       out  m_tvalid/m_tready  m_tdata verdict and warning flag
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wr_data
//
// clear and append items give no result and leave the block idle for the next item.
// a check holds s_tready low until its result is loaded: the probe walks the
// cell row one cell per cycle, the hits are captured as the sequencer moves to
// finish, and there the verdict is resolved and loaded into the output register,
// once that is free, as the block returns to idle.
// aresetn is synchronous, active low; it empties all lists and the config.
// a finished result waits in the output register while the next item is taken;
// a second check holds before its result until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module virtual_ip_subnet_admission_check #(
    parameter int LIST_DEPTH = vipsac_pkg::LIST_DEPTH_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration writes
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic         cfg_wr_data,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // from bit 0: subnet_high[63:0], subnet_low[127:64], prefix_len[135:128],
    // subnet_is_v6[136], peer_high[200:137], peer_low[264:201],
    // peer_is_v6[265], zero pad[271:266]
    input  wire logic [271:0] s_tdata,
    // from bit 0: kind[2:0]
    input  wire logic [2:0]   s_tuser,
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // from bit 0: verdict[2:0], all_warning[3], zero pad[7:4]
    output logic [7:0]        m_tdata
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    vipsac_pkg::state_t    state_reg, state_next;
    logic                  virt_present_reg, host_only_reg, allow_own_reg;
    logic                  use_private_reg, allow_all_reg;
    logic [CNT_W-1:0]      incl_count_reg, excl_count_reg, spec_count_reg;
    vipsac_pkg::net_t      subnet_reg;
    logic                  own_match_reg;
    logic                  start_reg, start_next;
    vipsac_pkg::list_sel_t hit_reg;
    logic                  m_valid_reg, m_valid_next;
    vipsac_pkg::verdict_t  m_verdict_reg;
    logic                  m_warn_reg;

    vipsac_pkg::kind_t     in_kind;
    vipsac_pkg::net_t      in_net;
    vipsac_pkg::net_t      in_peer;
    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    logic                  capture_hits;
    vipsac_pkg::list_sel_t wr_req;
    vipsac_pkg::probe_t    probe_in;
    vipsac_pkg::probe_t    probe_out;
    vipsac_pkg::verdict_t  verdict;
    logic                  warn;
    logic                  is_full_len;

    // unpack and normalise the incoming item
    assign in_kind  = vipsac_pkg::kind_t'(s_tuser);
    assign in_net   = vipsac_pkg::make_net(s_tdata[63:0], s_tdata[127:64],
                                           s_tdata[135:128], s_tdata[136]);
    assign in_peer  = vipsac_pkg::make_net(s_tdata[200:137], s_tdata[264:201],
                                           8'hFF, s_tdata[265]);
    assign s_tready = (state_reg == vipsac_pkg::ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;

    // append requests, dropped when the list is full
    always_comb begin
        wr_req.incl = 1'b0;
        wr_req.excl = 1'b0;
        wr_req.spec = 1'b0;
        if (accept) begin
            unique case (in_kind)
                vipsac_pkg::KIND_ADD_INCL: begin
                    wr_req.incl = (incl_count_reg != CNT_W'(LIST_DEPTH));
                end
                vipsac_pkg::KIND_ADD_EXCL: begin
                    wr_req.excl = (excl_count_reg != CNT_W'(LIST_DEPTH));
                end
                vipsac_pkg::KIND_ADD_SPEC: begin
                    wr_req.spec = (spec_count_reg != CNT_W'(LIST_DEPTH));
                end
                default: begin
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            virt_present_reg <= 1'b0;
            host_only_reg    <= 1'b0;
            allow_own_reg    <= 1'b0;
            use_private_reg  <= 1'b0;
            allow_all_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (vipsac_pkg::cfg_idx_t'(cfg_index))
                vipsac_pkg::CFG_VIRT_PRESENT: virt_present_reg <= cfg_wr_data;
                vipsac_pkg::CFG_HOST_ONLY:    host_only_reg    <= cfg_wr_data;
                vipsac_pkg::CFG_ALLOW_OWN:    allow_own_reg    <= cfg_wr_data;
                vipsac_pkg::CFG_USE_PRIVATE:  use_private_reg  <= cfg_wr_data;
                vipsac_pkg::CFG_ALLOW_ALL:    allow_all_reg    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // list fill levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            incl_count_reg <= '0;
            excl_count_reg <= '0;
            spec_count_reg <= '0;
        end else if (accept && (in_kind == vipsac_pkg::KIND_CLEAR)) begin
            incl_count_reg <= '0;
            excl_count_reg <= '0;
            spec_count_reg <= '0;
        end else begin
            if (wr_req.incl) begin
                incl_count_reg <= incl_count_reg + CNT_W'(1);
            end
            if (wr_req.excl) begin
                excl_count_reg <= excl_count_reg + CNT_W'(1);
            end
            if (wr_req.spec) begin
                spec_count_reg <= spec_count_reg + CNT_W'(1);
            end
        end
    end

    // the row of list cells
    assign probe_in.valid    = start_reg;
    assign probe_in.net      = subnet_reg;
    assign probe_in.hit.incl = 1'b0;
    assign probe_in.hit.excl = 1'b0;
    assign probe_in.hit.spec = 1'b0;

    vipsac_chain #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_req     (wr_req),
        .wr_data    (in_net),
        .incl_count (incl_count_reg),
        .excl_count (excl_count_reg),
        .spec_count (spec_count_reg),
        .probe_in   (probe_in),
        .probe_out  (probe_out)
    );

    // sequencer: next state and strobes
    always_comb begin
        state_next   = state_reg;
        start_next   = 1'b0;
        capture_hits = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            vipsac_pkg::ST_IDLE: begin
                if (accept && (in_kind == vipsac_pkg::KIND_CHECK)) begin
                    start_next = 1'b1;
                    state_next = vipsac_pkg::ST_RUN;
                end
            end
            vipsac_pkg::ST_RUN: begin
                if (probe_out.valid) begin
                    capture_hits = 1'b1;
                    state_next   = vipsac_pkg::ST_FINISH;
                end
            end
            vipsac_pkg::ST_FINISH: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = vipsac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vipsac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vipsac_pkg::ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    // check operands and list hits
    always_ff @(posedge aclk) begin
        if (start_next) begin
            subnet_reg    <= in_net;
            own_match_reg <= (in_net.plen == (in_net.v6 ? vipsac_pkg::V6_FULL
                                                         : vipsac_pkg::V4_FULL)) &&
                             (in_net.v6 == in_peer.v6) &&
                             (in_net.hi == in_peer.hi) && (in_net.lo == in_peer.lo);
        end
        if (capture_hits) begin
            hit_reg <= probe_out.hit;
        end
    end

    // rule order resolves the verdict
    assign is_full_len = subnet_reg.plen == (subnet_reg.v6 ? vipsac_pkg::V6_FULL
                                                          : vipsac_pkg::V4_FULL);

    always_comb begin
        verdict = vipsac_pkg::VERD_OK;
        warn    = 1'b0;
        priority if (!virt_present_reg) begin
            verdict = vipsac_pkg::VERD_OK;
        end else if (host_only_reg && !is_full_len) begin
            verdict = vipsac_pkg::VERD_HOST_ONLY;
        end else if (incl_count_reg == '0) begin
            verdict = vipsac_pkg::VERD_OK;
        end else if (allow_own_reg && own_match_reg) begin
            verdict = vipsac_pkg::VERD_OK;
        end else if (use_private_reg && hit_reg.incl && !hit_reg.excl) begin
            verdict = vipsac_pkg::VERD_OK;
        end else if ((spec_count_reg != '0) && hit_reg.spec) begin
            verdict = vipsac_pkg::VERD_OK;
        end else if (allow_all_reg) begin
            verdict = vipsac_pkg::VERD_OK;
            warn    = 1'b1;
        end else if (spec_count_reg != '0) begin
            verdict = vipsac_pkg::VERD_NOT_SPEC;
        end else if (use_private_reg && !hit_reg.incl) begin
            verdict = vipsac_pkg::VERD_NOT_PRIV;
        end else if (use_private_reg) begin
            verdict = vipsac_pkg::VERD_EXCLUDED;
        end else begin
            verdict = vipsac_pkg::VERD_OK;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load_out) begin
            m_verdict_reg <= verdict;
            m_warn_reg    <= warn;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_warn_reg, m_verdict_reg};

    // the probe only leaves the row while a check is running
    a_probe_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        probe_out.valid |-> (state_reg == vipsac_pkg::ST_RUN))
        else $error("probe left the cell row outside a running check");

    // a new result only follows the finish step
    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == vipsac_pkg::ST_FINISH))
        else $error("result raised without a finished check");

    // fill levels never pass the list depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (incl_count_reg <= CNT_W'(LIST_DEPTH)) && (excl_count_reg <= CNT_W'(LIST_DEPTH)) &&
        (spec_count_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list fill level beyond depth");

endmodule

`default_nettype wire
